FILE: rtl/core/slsp_pkg.sv
// shared constants, types and the crc-8 step for the sensor poll and parse block
// no dependencies
package slsp_pkg;

  localparam int unsigned FRAME_BYTES = 11;
  localparam int unsigned COUNT_WRAP  = 200;

  localparam logic [7:0] REQ_COMMAND = 8'h06;
  localparam logic [7:0] CRC_POLY    = 8'h07;

  // configuration register indexes
  localparam logic [1:0] REG_SENSOR_ADDRESS  = 2'd0;
  localparam logic [1:0] REG_REQUEST_PREFIX  = 2'd1;
  localparam logic [1:0] REG_RESPONSE_PREFIX = 2'd2;

  // result kinds
  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_FRAME   = 1'b1;

  // input selector
  localparam logic FUNC_RX_BYTE = 1'b0;
  localparam logic FUNC_POLL    = 1'b1;

  localparam int unsigned REQ_BYTES = 4;

  typedef logic [3:0] byte_idx_t;
  typedef logic [1:0] req_idx_t;

  localparam byte_idx_t LAST_IDX = byte_idx_t'(FRAME_BYTES - 1);
  localparam req_idx_t  REQ_LAST = req_idx_t'(REQ_BYTES - 1);

  typedef struct packed {
    logic frame_end;  // next rx item completes a frame
    logic found;      // high when frames completed since the previous poll
  } parse_status_t;

  typedef struct packed {
    logic [7:0]  opcode;
    logic [7:0]  temperature;
    logic [15:0] level;
    logic [31:0] frequency;
  } frame_fields_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/slsp_parser.sv
// response frame parser: prefix hunt, byte capture, frame counter
// depends on slsp_pkg
module slsp_parser import slsp_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          byte_en,
  input  logic          poll_en,
  input  logic [7:0]    rx_byte,
  input  logic [7:0]    response_prefix,
  output parse_status_t status,
  output frame_fields_t fields
);

  logic       in_frame_r;
  byte_idx_t  byte_index_r;
  logic [7:0] cap_r [8];
  logic [7:0] frame_count_r;
  logic [7:0] last_seen_r;
  logic [7:0] view [8];
  logic       cap_hit;
  logic [2:0] cap_sel;

  assign cap_hit = in_frame_r && (byte_index_r >= 4'd2) && (byte_index_r <= 4'd9);
  assign cap_sel = 3'(byte_index_r - 4'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r    <= 1'b0;
      byte_index_r  <= '0;
      frame_count_r <= '0;
      last_seen_r   <= '0;
    end else begin
      if (poll_en) begin
        last_seen_r <= frame_count_r;
      end
      if (byte_en) begin
        if (!in_frame_r) begin
          if (rx_byte == response_prefix) begin
            in_frame_r   <= 1'b1;
            byte_index_r <= 4'd1;
          end
        end else if (byte_index_r == LAST_IDX) begin
          frame_count_r <= (frame_count_r == 8'(COUNT_WRAP)) ? 8'd0 : frame_count_r + 8'd1;
          in_frame_r    <= 1'b0;
          byte_index_r  <= '0;
        end else begin
          byte_index_r <= byte_index_r + 4'd1;
        end
      end
    end
  end

  // capture store, no reset
  always_ff @(posedge clk) begin
    if (byte_en && cap_hit) begin
      cap_r[cap_sel] <= rx_byte;
    end
  end

  // bypass the byte being written so the fields show it in the same cycle
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      view[i] = (cap_hit && (cap_sel == 3'(i))) ? rx_byte : cap_r[i];
    end
  end

  assign status.frame_end = in_frame_r && (byte_index_r == LAST_IDX);
  assign status.found     = (frame_count_r != last_seen_r);

  assign fields.opcode      = view[0];
  assign fields.temperature = view[1];
  assign fields.level       = {view[3], view[2]};
  assign fields.frequency   = {view[7], view[6], view[5], view[4]};

endmodule

FILE: rtl/core/slsp_request.sv
// request frame builder: crc-8 over prefix, address and command, byte select
// depends on slsp_pkg
module slsp_request import slsp_pkg::*; (
  input  logic       clk,
  input  logic [7:0] request_prefix,
  input  logic [7:0] sensor_address,
  input  req_idx_t   sel,
  output logic [7:0] req_byte
);

  logic [7:0] crc_r;
  logic [7:0] crc_nxt;

  assign crc_nxt = crc8_step(crc8_step(crc8_step(8'd0, request_prefix), sensor_address),
                             REQ_COMMAND);

  // the user must see config only moves while idle; it is not enforced
  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
  end

  always_comb begin
    case (sel)
      2'd0:    req_byte = request_prefix;
      2'd1:    req_byte = sensor_address;
      2'd2:    req_byte = REQ_COMMAND;
      2'd3:    req_byte = crc_r;
      default: req_byte = crc_r;
    endcase
  end

endmodule

FILE: rtl/core/serial_level_sensor_poll_and_parse.sv
// top level of the polled serial level sensor block: input register, output register, config
// depends on slsp_pkg, slsp_parser, slsp_request
//
//  channel   direction  handshake          payload
//  in_       slave      tvalid/tready      tuser = func, tdata[7:0] = rx_byte
//  out_      master     tvalid/tready      tuser = kind, tlast = last, tdata = other fields
//  cfg_      write      cfg_we             cfg_index selects register, cfg_wdata value
//
// a rx byte that closes a frame gives one result; a poll gives four results, one per cycle
// on the output register while out_tready holds; a new item with a result waits until the
// last result is taken; rx bytes without a result pass even while a poll drains
// input register and output register part the two sides; nothing else holds items
// reset is synchronous: parser state, counters and valid flags clear, config
// returns to address 1, request prefix 0x31 and response prefix 0x3e
module serial_level_sensor_poll_and_parse import slsp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [7:0] tx_byte, [8] new_frames, [16:9] opcode,
                                  // [24:17] temperature, [40:25] level, [72:41] frequency
  output logic        out_tuser,  // [0] kind
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  // configuration registers
  logic [7:0] sensor_address_r;
  logic [7:0] request_prefix_r;
  logic [7:0] response_prefix_r;

  // input register
  logic       a_valid_r;
  logic       a_func_r;
  logic [7:0] a_byte_r;

  // output register
  logic        out_valid_r;
  logic        out_kind_r;
  logic [7:0]  out_tx_r;
  logic        out_last_r;
  logic        out_found_r;
  logic [7:0]  out_op_r;
  logic [7:0]  out_temp_r;
  logic [15:0] out_level_r;
  logic [31:0] out_freq_r;
  req_idx_t    req_idx_r;

  parse_status_t pstat;
  frame_fields_t pfields;
  logic          a_poll;
  logic          a_res;
  logic          out_take;
  logic          out_free;
  logic          fire;
  req_idx_t      req_sel;
  logic [7:0]    req_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sensor_address_r  <= 8'd1;
      request_prefix_r  <= 8'h31;
      response_prefix_r <= 8'h3e;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SENSOR_ADDRESS:  sensor_address_r  <= cfg_wdata;
        REG_REQUEST_PREFIX:  request_prefix_r  <= cfg_wdata;
        REG_RESPONSE_PREFIX: response_prefix_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // an item moves on when the output slot frees up, or at once if it gives no result
  assign a_poll   = (a_func_r == FUNC_POLL);
  assign a_res    = a_poll || pstat.frame_end;
  assign out_take = out_valid_r && out_tready;
  assign out_free = !out_valid_r || (out_take && out_last_r);
  assign fire     = a_valid_r && (out_free || !a_res);
  assign in_tready = !a_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_tready) begin
      a_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      a_func_r <= in_tuser;
      a_byte_r <= in_tdata;
    end
  end

  slsp_parser u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .byte_en         (fire && !a_poll),
    .poll_en         (fire && a_poll),
    .rx_byte         (a_byte_r),
    .response_prefix (response_prefix_r),
    .status          (pstat),
    .fields          (pfields)
  );

  // first request byte on load, then the next one per accepted result
  assign req_sel = (fire && a_poll) ? req_idx_t'(0) : req_idx_r + req_idx_t'(1);

  slsp_request u_request (
    .clk            (clk),
    .request_prefix (request_prefix_r),
    .sensor_address (sensor_address_r),
    .sel            (req_sel),
    .req_byte       (req_byte)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      req_idx_r   <= '0;
    end else if (fire && a_res) begin
      out_valid_r <= 1'b1;
      req_idx_r   <= '0;
    end else if (out_take && !out_last_r) begin
      req_idx_r <= req_sel;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && a_res) begin
      if (a_poll) begin
        out_kind_r  <= KIND_REQUEST;
        out_tx_r    <= req_byte;
        out_last_r  <= 1'b0;
        out_found_r <= pstat.found;
        out_op_r    <= '0;
        out_temp_r  <= '0;
        out_level_r <= '0;
        out_freq_r  <= '0;
      end else begin
        out_kind_r  <= KIND_FRAME;
        out_tx_r    <= '0;
        out_last_r  <= 1'b1;
        out_found_r <= 1'b1;
        out_op_r    <= pfields.opcode;
        out_temp_r  <= pfields.temperature;
        out_level_r <= pfields.level;
        out_freq_r  <= pfields.frequency;
      end
    end else if (out_take && !out_last_r) begin
      // next request byte, found flag held across the run
      out_tx_r   <= req_byte;
      out_last_r <= (req_sel == REQ_LAST);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {7'd0, out_freq_r, out_level_r, out_temp_r, out_op_r, out_found_r,
                       out_tx_r};

endmodule
